### hdl/tte_pkg.sv
// shared constants, types and helper function for the terminal engine
`timescale 1ns / 1ps
package tte_pkg;

    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int MAX_ARGS = 16;
    localparam int CELLS    = COLUMNS * ROWS;

    localparam int COL_W   = $clog2(COLUMNS + 1);
    localparam int ROW_W   = $clog2(ROWS);
    localparam int ROWN_W  = $clog2(ROWS + 1);
    localparam int ADDR_W  = $clog2(CELLS + 1);
    localparam int RAM_AW  = $clog2(CELLS);
    localparam int SLOT_W  = $clog2(MAX_ARGS);
    localparam int ARGC_W  = $clog2(MAX_ARGS + 1);
    localparam int ARG_W   = 16;
    localparam int ARG_MAX = 65535;
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int CELL_W  = 16;
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

    localparam logic [CHAR_W-1:0] CH_NUL  = 8'h00;
    localparam logic [CHAR_W-1:0] CH_LF   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_ESC  = 8'h1B;
    localparam logic [CHAR_W-1:0] CH_LBR  = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_SEMI = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_LC   = 8'h63;
    localparam logic [CHAR_W-1:0] CH_0    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9    = 8'h39;

    // control sequence final bytes
    localparam logic [CHAR_W-1:0] FIN_CUU = 8'h41;
    localparam logic [CHAR_W-1:0] FIN_CUD = 8'h42;
    localparam logic [CHAR_W-1:0] FIN_CUF = 8'h43;
    localparam logic [CHAR_W-1:0] FIN_CUB = 8'h44;
    localparam logic [CHAR_W-1:0] FIN_CNL = 8'h45;
    localparam logic [CHAR_W-1:0] FIN_CPL = 8'h46;
    localparam logic [CHAR_W-1:0] FIN_CHA = 8'h47;
    localparam logic [CHAR_W-1:0] FIN_CUP = 8'h48;
    localparam logic [CHAR_W-1:0] FIN_HVP = 8'h66;
    localparam logic [CHAR_W-1:0] FIN_ED  = 8'h4A;
    localparam logic [CHAR_W-1:0] FIN_EL  = 8'h4B;
    localparam logic [CHAR_W-1:0] FIN_SU  = 8'h53;
    localparam logic [CHAR_W-1:0] FIN_SD  = 8'h54;
    localparam logic [CHAR_W-1:0] FIN_VPA = 8'h64;
    localparam logic [CHAR_W-1:0] FIN_SGR = 8'h6D;
    localparam logic [CHAR_W-1:0] FIN_SCP = 8'h73;
    localparam logic [CHAR_W-1:0] FIN_RCP = 8'h75;

    localparam logic [2:0] FG_MAP [8] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_ESC,
        MODE_CSI
    } t_mode;

    typedef enum logic [2:0] {
        BC_NUL,
        BC_LF,
        BC_ESC,
        BC_DIGIT,
        BC_SEMI,
        BC_LBR,
        BC_LC,
        BC_OTHER
    } t_byte_cls;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_CLEAR,
        ST_SGR,
        ST_PRINT
    } t_state;

    typedef enum logic [2:0] {
        ACT_DONE,
        ACT_WRITE,
        ACT_READ,
        ACT_CLEAR,
        ACT_SCROLL_UP,
        ACT_SCROLL_DN,
        ACT_SGR
    } t_act;

    typedef struct packed {
        logic              cmd;
        logic [CHAR_W-1:0] char_byte;
        logic [ADDR_W-1:0] cell_address;
        t_byte_cls         cls;
    } t_item;

    typedef struct packed {
        logic init_busy;
    } t_back_status;

    function automatic logic [ATTR_W-1:0] sgr_apply(
        input logic [ATTR_W-1:0] a,
        input logic [ARG_W-1:0]  v,
        input logic [ATTR_W-1:0] dflt
    );
        logic [ATTR_W-1:0] r;
        r = a;
        if (v == ARG_W'(0)) begin
            r = dflt;
        end else if (v == ARG_W'(1)) begin
            r = a | 8'h08;
        end else if (v == ARG_W'(22)) begin
            r = a & ~8'h08;
        end else if (v >= ARG_W'(30) && v <= ARG_W'(37)) begin
            r = (a & 8'hF8) | {5'b0, FG_MAP[3'(v - ARG_W'(30))]};
        end else if (v == ARG_W'(39)) begin
            r = (a & 8'hF8) | 8'h07;
        end else if (v >= ARG_W'(40) && v <= ARG_W'(47)) begin
            r = (a & 8'h0F) | {1'b0, FG_MAP[3'(v - ARG_W'(40))], 4'b0};
        end else if (v == ARG_W'(49)) begin
            r = a & 8'h0F;
        end
        return r;
    endfunction

endpackage

### hdl/tte_if.sv
// request and result channels of the terminal engine
`timescale 1ns / 1ps
interface tte_in_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [tte_pkg::CHAR_W-1:0]  char_byte;
    logic [tte_pkg::ADDR_W-1:0]  cell_address;

    modport source (output valid, cmd, char_byte, cell_address, input ready);
    modport sink   (input valid, cmd, char_byte, cell_address, output ready);
endinterface

interface tte_out_if;
    logic                        valid;
    logic                        ready;
    logic [tte_pkg::CELL_W-1:0]  cell_data;
    logic [tte_pkg::COL_W-1:0]   cursor_col;
    logic [tte_pkg::ROW_W-1:0]   cursor_row;
    logic [tte_pkg::ATTR_W-1:0]  current_attribute;
    logic [1:0]                  parse_mode;

    modport source (output valid, cell_data, cursor_col, cursor_row, current_attribute,
                    parse_mode, input ready);
    modport sink   (input valid, cell_data, cursor_col, cursor_row, current_attribute,
                    parse_mode, output ready);
endinterface

### hdl/tte_ram.sv
// generic single write, single registered read ram
`timescale 1ns / 1ps
module tte_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hdl/tte_front.sv
// request intake, byte classification and two-entry queue
`timescale 1ns / 1ps
module tte_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tte_in_if.sink                i_item,
    input  tte_pkg::t_back_status i_status,
    input  logic                  i_pop,
    output logic                  o_q_valid,
    output tte_pkg::t_item        o_q_item
);
    import tte_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item             r_slots [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wptr, n_wptr;
    logic [PTR_W-1:0]  r_rptr, n_rptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              w_push;
    t_item             w_new;

    function automatic t_byte_cls classify(input logic [CHAR_W-1:0] c);
        t_byte_cls k;
        k = BC_OTHER;
        if (c == CH_NUL) k = BC_NUL;
        else if (c == CH_LF) k = BC_LF;
        else if (c == CH_ESC) k = BC_ESC;
        else if (c >= CH_0 && c <= CH_9) k = BC_DIGIT;
        else if (c == CH_SEMI) k = BC_SEMI;
        else if (c == CH_LBR) k = BC_LBR;
        else if (c == CH_LC) k = BC_LC;
        return k;
    endfunction

    assign i_item.ready = (r_count != CNT_W'(QUEUE_DEPTH)) && !i_status.init_busy;
    assign w_push       = i_item.valid && i_item.ready;

    always_comb begin
        w_new.cmd          = i_item.cmd;
        w_new.char_byte    = i_item.char_byte;
        w_new.cell_address = i_item.cell_address;
        w_new.cls          = classify(i_item.char_byte);
    end

    always_comb begin
        n_wptr  = w_push ? PTR_W'(r_wptr + 1'b1) : r_wptr;
        n_rptr  = i_pop ? PTR_W'(r_rptr + 1'b1) : r_rptr;
        n_count = CNT_W'(r_count + CNT_W'(w_push) - CNT_W'(i_pop));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slots[r_wptr] <= w_new;
        end
    end

    assign o_q_valid = (r_count != '0);
    assign o_q_item  = r_slots[r_rptr];
endmodule

### hdl/tte_back.sv
// execution side: cursor and parser state, screen walks and result register
`timescale 1ns / 1ps
module tte_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [tte_pkg::ATTR_W-1:0]   i_default_attr,
    input  logic                         i_q_valid,
    input  tte_pkg::t_item               i_q_item,
    output logic                         o_pop,
    output tte_pkg::t_back_status        o_status,
    tte_out_if.source                    o_result
);
    import tte_pkg::*;

    t_state             r_state, n_state;
    logic [COL_W-1:0]   r_col, n_col, r_saved_col, n_saved_col;
    logic [ROW_W-1:0]   r_row, n_row, r_saved_row, n_saved_row;
    logic [ATTR_W-1:0]  r_attr, n_attr;
    t_mode              r_mode, n_mode;
    logic [ARG_W-1:0]   r_args [MAX_ARGS];
    logic [ARG_W-1:0]   n_args [MAX_ARGS];
    logic               r_present [MAX_ARGS];
    logic               n_present [MAX_ARGS];
    logic [ARGC_W-1:0]  r_slot, n_slot;
    logic               r_out_valid, n_out_valid;
    logic [CELL_W-1:0]  r_cell_data, n_cell_data;
    logic [ADDR_W-1:0]  r_src, n_src, r_dst, n_dst;
    logic [ADDR_W-1:0]  r_copy_left, n_copy_left;
    logic               r_down, n_down;
    logic [ADDR_W-1:0]  r_clr_addr, n_clr_addr, r_clr_to, n_clr_to;
    logic               r_init_done, n_init_done;
    logic               r_pend, n_pend;
    logic [ADDR_W-1:0]  r_pend_addr, n_pend_addr;
    logic [CELL_W-1:0]  r_pend_data, n_pend_data;
    logic [SLOT_W-1:0]  r_sgr_idx, n_sgr_idx;
    logic               r_sgr_any, n_sgr_any;
    logic               r_read_oob, n_read_oob;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [CELL_W-1:0]  ram_wdata, ram_rdata;

    t_act               w_act;
    logic               w_pop;
    logic [ADDR_W-1:0]  w_copy_cnt;
    logic               w_clr_last;
    logic [ARG_W-1:0]   w_p, w_p1, w_s;
    logic [ARG_W:0]     w_row_sum, w_col_sum;
    logic [ADDR_W-1:0]  w_here, w_start;
    logic [ROWN_W-1:0]  w_n;
    logic [SLOT_W-1:0]  w_slot;
    logic [ARG_W+3:0]   w_dig;
    logic [ATTR_W-1:0]  w_sgr_attr;

    tte_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (RAM_AW'(ram_waddr)),
        .i_wdata (ram_wdata),
        .i_raddr (RAM_AW'(ram_raddr)),
        .o_rdata (ram_rdata)
    );

    // argument views and cursor arithmetic
    assign w_p       = r_present[0] ? r_args[0] : ARG_W'(1);
    assign w_s       = r_present[0] ? r_args[0] : ARG_W'(0);
    assign w_p1      = r_present[1] ? r_args[1] : ARG_W'(1);
    assign w_row_sum = {1'b0, w_p} + (ARG_W+1)'(r_row);
    assign w_col_sum = {1'b0, w_p} + (ARG_W+1)'(r_col);
    assign w_start   = ADDR_W'(r_row * COLUMNS);
    assign w_here    = ADDR_W'(w_start + ADDR_W'(r_col));
    assign w_n       = (w_p >= ARG_W'(ROWS)) ? ROWN_W'(ROWS) : ROWN_W'(w_p);
    assign w_slot    = r_slot[SLOT_W-1:0];
    assign w_dig     = (ARG_W+4)'(r_args[w_slot]) * (ARG_W+4)'(10)
                     + (ARG_W+4)'(i_q_item.char_byte - CH_0);
    assign w_sgr_attr = sgr_apply(r_attr, r_args[0], i_default_attr);
    assign w_clr_last = (ADDR_W'(r_clr_addr + 1'b1) == r_clr_to);

    assign w_pop = (r_state == ST_IDLE) && i_q_valid && (!r_out_valid || o_result.ready);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_pop) begin
                    case (w_act)
                        ACT_READ:  n_state = ST_READ;
                        ACT_CLEAR: n_state = ST_CLEAR;
                        ACT_SCROLL_UP,
                        ACT_SCROLL_DN: n_state = (w_copy_cnt != '0) ? ST_COPY_RD : ST_CLEAR;
                        ACT_SGR:   n_state = ST_SGR;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_READ:    n_state = ST_IDLE;
            ST_COPY_RD: n_state = ST_COPY_WR;
            ST_COPY_WR: n_state = (r_copy_left == ADDR_W'(1)) ? ST_CLEAR : ST_COPY_RD;
            ST_CLEAR: begin
                if (w_clr_last) begin
                    n_state = r_pend ? ST_PRINT : ST_IDLE;
                end
            end
            ST_PRINT:   n_state = ST_IDLE;
            ST_SGR: begin
                if (r_sgr_idx == SLOT_W'(MAX_ARGS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        logic [ROWN_W-1:0] sc_n;
        logic [ADDR_W-1:0] lo, hi;
        n_col       = r_col;
        n_row       = r_row;
        n_saved_col = r_saved_col;
        n_saved_row = r_saved_row;
        n_attr      = r_attr;
        n_mode      = r_mode;
        n_args      = r_args;
        n_present   = r_present;
        n_slot      = r_slot;
        n_out_valid = r_out_valid && !o_result.ready;
        n_cell_data = r_cell_data;
        n_src       = r_src;
        n_dst       = r_dst;
        n_copy_left = r_copy_left;
        n_down      = r_down;
        n_clr_addr  = r_clr_addr;
        n_clr_to    = r_clr_to;
        n_init_done = r_init_done;
        n_pend      = r_pend;
        n_pend_addr = r_pend_addr;
        n_pend_data = r_pend_data;
        n_sgr_idx   = r_sgr_idx;
        n_sgr_any   = r_sgr_any;
        n_read_oob  = r_read_oob;
        w_act       = ACT_DONE;
        w_copy_cnt  = '0;
        ram_we      = 1'b0;
        ram_waddr   = r_clr_addr;
        ram_wdata   = '0;
        ram_raddr   = r_src;
        o_pop       = 1'b0;
        sc_n        = '0;
        lo          = '0;
        hi          = ADDR_W'(CELLS);

        case (r_state)
            ST_IDLE: begin
                if (w_pop) begin
                    o_pop = 1'b1;
                    if (i_q_item.cmd) begin
                        w_act      = ACT_READ;
                        ram_raddr  = i_q_item.cell_address;
                        n_read_oob = (i_q_item.cell_address >= ADDR_W'(CELLS));
                    end else begin
                        case (r_mode)
                            MODE_NORMAL: begin
                                case (i_q_item.cls)
                                    BC_ESC: n_mode = MODE_ESC;
                                    BC_NUL: begin
                                        n_col = '0;
                                        n_row = '0;
                                        w_act = ACT_CLEAR;
                                    end
                                    BC_LF: begin
                                        n_col = '0;
                                        if (r_row == ROW_W'(ROWS - 1)) begin
                                            w_act = ACT_SCROLL_UP;
                                            sc_n  = ROWN_W'(1);
                                        end else begin
                                            n_row = ROW_W'(r_row + 1'b1);
                                        end
                                    end
                                    default: begin
                                        // printable byte, with deferred wrap
                                        ram_wdata = {r_attr, i_q_item.char_byte};
                                        if (r_col > COL_W'(COLUMNS - 1)) begin
                                            n_col = COL_W'(1);
                                            if (r_row == ROW_W'(ROWS - 1)) begin
                                                w_act       = ACT_SCROLL_UP;
                                                sc_n        = ROWN_W'(1);
                                                n_pend      = 1'b1;
                                                n_pend_addr = ADDR_W'((ROWS - 1) * COLUMNS);
                                                n_pend_data = {r_attr, i_q_item.char_byte};
                                            end else begin
                                                n_row     = ROW_W'(r_row + 1'b1);
                                                w_act     = ACT_WRITE;
                                                ram_waddr = ADDR_W'(w_start + ADDR_W'(COLUMNS));
                                            end
                                        end else begin
                                            w_act     = ACT_WRITE;
                                            ram_waddr = w_here;
                                            n_col     = COL_W'(r_col + 1'b1);
                                        end
                                    end
                                endcase
                            end
                            MODE_ESC: begin
                                n_mode = MODE_NORMAL;
                                case (i_q_item.cls)
                                    BC_LBR: begin
                                        for (int i = 0; i < MAX_ARGS; i++) begin
                                            n_args[i]    = '0;
                                            n_present[i] = 1'b0;
                                        end
                                        n_slot = '0;
                                        n_mode = MODE_CSI;
                                    end
                                    BC_LC: begin
                                        n_col       = '0;
                                        n_row       = '0;
                                        n_saved_col = '0;
                                        n_saved_row = '0;
                                        n_attr      = i_default_attr;
                                        w_act       = ACT_CLEAR;
                                    end
                                    default: ;
                                endcase
                            end
                            default: begin
                                case (i_q_item.cls)
                                    BC_DIGIT: begin
                                        n_args[w_slot]    = (w_dig > (ARG_W+4)'(ARG_MAX)) ?
                                                            ARG_W'(ARG_MAX) : ARG_W'(w_dig);
                                        n_present[w_slot] = 1'b1;
                                    end
                                    BC_SEMI: begin
                                        n_slot = ARGC_W'(r_slot + 1'b1);
                                        if (n_slot >= ARGC_W'(MAX_ARGS)) begin
                                            n_mode = MODE_NORMAL;
                                        end
                                    end
                                    default: begin
                                        n_mode = MODE_NORMAL;
                                        case (i_q_item.char_byte)
                                            FIN_CUU: n_row = (w_p > ARG_W'(r_row)) ? '0 :
                                                             ROW_W'(ARG_W'(r_row) - w_p);
                                            FIN_CUD: n_row = (w_row_sum >= (ARG_W+1)'(ROWS)) ?
                                                             ROW_W'(ROWS - 1) : ROW_W'(w_row_sum);
                                            FIN_CUF: n_col = (w_col_sum >= (ARG_W+1)'(COLUMNS)) ?
                                                             COL_W'(COLUMNS - 1) : COL_W'(w_col_sum);
                                            FIN_CUB: n_col = (w_p > ARG_W'(r_col)) ? '0 :
                                                             COL_W'(ARG_W'(r_col) - w_p);
                                            FIN_CNL: begin
                                                n_row = (w_row_sum >= (ARG_W+1)'(ROWS)) ?
                                                        ROW_W'(ROWS - 1) : ROW_W'(w_row_sum);
                                                n_col = '0;
                                            end
                                            FIN_CPL: begin
                                                n_row = (w_p > ARG_W'(r_row)) ? '0 :
                                                        ROW_W'(ARG_W'(r_row) - w_p);
                                                n_col = '0;
                                            end
                                            FIN_CHA: begin
                                                if (w_p != '0 && w_p <= ARG_W'(COLUMNS)) begin
                                                    n_col = COL_W'(w_p - 1'b1);
                                                end
                                            end
                                            FIN_CUP, FIN_HVP: begin
                                                if (w_p1 != '0 && w_p1 <= ARG_W'(COLUMNS) &&
                                                    w_p != '0 && w_p <= ARG_W'(ROWS)) begin
                                                    n_col = COL_W'(w_p1 - 1'b1);
                                                    n_row = ROW_W'(w_p - 1'b1);
                                                end
                                            end
                                            FIN_ED, FIN_EL: begin
                                                if (i_q_item.char_byte == FIN_ED) begin
                                                    lo = (w_s == ARG_W'(0)) ? w_here : '0;
                                                    hi = (w_s == ARG_W'(1)) ? w_here :
                                                         ADDR_W'(CELLS);
                                                end else begin
                                                    lo = (w_s == ARG_W'(0)) ? w_here : w_start;
                                                    hi = (w_s == ARG_W'(1)) ? w_here :
                                                         ADDR_W'(w_start + ADDR_W'(COLUMNS));
                                                end
                                                if (w_s <= ARG_W'(2) && lo < hi) begin
                                                    w_act = ACT_CLEAR;
                                                end
                                            end
                                            FIN_SU: begin
                                                if (w_n != '0) begin
                                                    w_act = ACT_SCROLL_UP;
                                                    sc_n  = w_n;
                                                end
                                            end
                                            FIN_SD: begin
                                                if (w_n != '0) begin
                                                    w_act = ACT_SCROLL_DN;
                                                    sc_n  = w_n;
                                                end
                                            end
                                            FIN_VPA: begin
                                                if (w_p != '0 && w_p <= ARG_W'(ROWS)) begin
                                                    n_row = ROW_W'(w_p - 1'b1);
                                                end
                                            end
                                            FIN_SGR: begin
                                                w_act     = ACT_SGR;
                                                n_sgr_idx = '0;
                                                n_sgr_any = 1'b0;
                                            end
                                            FIN_SCP: begin
                                                n_saved_col = r_col;
                                                n_saved_row = r_row;
                                            end
                                            FIN_RCP: begin
                                                n_col = r_saved_col;
                                                n_row = r_saved_row;
                                            end
                                            default: ;
                                        endcase
                                    end
                                endcase
                            end
                        endcase
                    end

                    // walk set-up
                    w_copy_cnt = ADDR_W'((ROWS - sc_n) * COLUMNS);
                    case (w_act)
                        ACT_DONE, ACT_WRITE: begin
                            ram_we      = (w_act == ACT_WRITE);
                            n_out_valid = 1'b1;
                            n_cell_data = '0;
                        end
                        ACT_CLEAR: begin
                            n_clr_addr = lo;
                            n_clr_to   = hi;
                        end
                        ACT_SCROLL_UP: begin
                            n_copy_left = w_copy_cnt;
                            n_src       = ADDR_W'(sc_n * COLUMNS);
                            n_dst       = '0;
                            n_down      = 1'b0;
                            n_clr_addr  = w_copy_cnt;
                            n_clr_to    = ADDR_W'(CELLS);
                        end
                        ACT_SCROLL_DN: begin
                            n_copy_left = w_copy_cnt;
                            n_dst       = ADDR_W'(CELLS - 1);
                            n_src       = ADDR_W'(CELLS - 1 - sc_n * COLUMNS);
                            n_down      = 1'b1;
                            n_clr_addr  = '0;
                            n_clr_to    = ADDR_W'(sc_n * COLUMNS);
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                n_out_valid = 1'b1;
                n_cell_data = r_read_oob ? '0 : ram_rdata;
            end
            ST_COPY_RD: begin
                ram_raddr = r_src;
            end
            ST_COPY_WR: begin
                ram_we      = 1'b1;
                ram_waddr   = r_dst;
                ram_wdata   = ram_rdata;
                n_copy_left = ADDR_W'(r_copy_left - 1'b1);
                n_src       = r_down ? ADDR_W'(r_src - 1'b1) : ADDR_W'(r_src + 1'b1);
                n_dst       = r_down ? ADDR_W'(r_dst - 1'b1) : ADDR_W'(r_dst + 1'b1);
            end
            ST_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = ADDR_W'(r_clr_addr + 1'b1);
                if (w_clr_last) begin
                    n_init_done = 1'b1;
                    if (r_init_done && !r_pend) begin
                        n_out_valid = 1'b1;
                        n_cell_data = '0;
                    end
                end
            end
            ST_PRINT: begin
                ram_we      = 1'b1;
                ram_waddr   = r_pend_addr;
                ram_wdata   = r_pend_data;
                n_pend      = 1'b0;
                n_out_valid = 1'b1;
                n_cell_data = '0;
            end
            ST_SGR: begin
                // arguments shift down one slot per cycle, code taken from slot zero
                if (r_present[0]) begin
                    n_attr    = w_sgr_attr;
                    n_sgr_any = 1'b1;
                end
                for (int i = 0; i < MAX_ARGS - 1; i++) begin
                    n_args[i]    = r_args[i + 1];
                    n_present[i] = r_present[i + 1];
                end
                n_args[MAX_ARGS - 1]    = '0;
                n_present[MAX_ARGS - 1] = 1'b0;
                n_sgr_idx = SLOT_W'(r_sgr_idx + 1'b1);
                if (r_sgr_idx == SLOT_W'(MAX_ARGS - 1)) begin
                    if (!r_sgr_any && !r_present[0]) begin
                        n_attr = i_default_attr;
                    end
                    n_out_valid = 1'b1;
                    n_cell_data = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_col       <= '0;
            r_row       <= '0;
            r_saved_col <= '0;
            r_saved_row <= '0;
            r_attr      <= ATTR_RESET;
            r_mode      <= MODE_NORMAL;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
            r_clr_addr  <= '0;
            r_clr_to    <= ADDR_W'(CELLS);
            r_init_done <= 1'b0;
            r_pend      <= 1'b0;
            r_sgr_idx   <= '0;
            r_sgr_any   <= 1'b0;
            for (int i = 0; i < MAX_ARGS; i++) begin
                r_present[i] <= 1'b0;
            end
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_saved_col <= n_saved_col;
            r_saved_row <= n_saved_row;
            r_attr      <= n_attr;
            r_mode      <= n_mode;
            r_slot      <= n_slot;
            r_out_valid <= n_out_valid;
            r_clr_addr  <= n_clr_addr;
            r_clr_to    <= n_clr_to;
            r_init_done <= n_init_done;
            r_pend      <= n_pend;
            r_sgr_idx   <= n_sgr_idx;
            r_sgr_any   <= n_sgr_any;
            r_present   <= n_present;
        end
    end

    always_ff @(posedge i_clk) begin
        r_args      <= n_args;
        r_cell_data <= n_cell_data;
        r_src       <= n_src;
        r_dst       <= n_dst;
        r_copy_left <= n_copy_left;
        r_down      <= n_down;
        r_pend_addr <= n_pend_addr;
        r_pend_data <= n_pend_data;
        r_read_oob  <= n_read_oob;
    end

    assign o_status.init_busy         = !r_init_done;
    assign o_result.valid             = r_out_valid;
    assign o_result.cell_data         = r_cell_data;
    assign o_result.cursor_col        = r_col;
    assign o_result.cursor_row        = r_row;
    assign o_result.current_attribute = r_attr;
    assign o_result.parse_mode        = r_mode;

`ifndef SYNTHESIS
    a_no_result_while_walking: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> !r_out_valid)
        else $error("result pending while a walk is running");
    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= COL_W'(COLUMNS) && r_row <= ROW_W'(ROWS - 1))
        else $error("cursor off screen");
    a_write_in_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ram_waddr < ADDR_W'(CELLS))
        else $error("screen write beyond last cell");
    a_no_pop_during_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_init_done |-> !o_pop)
        else $error("request taken before clearing pass ended");
    a_sgr_leaves_csi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SGR |-> r_mode == MODE_NORMAL)
        else $error("parser not back to normal during colour walk");
`endif
endmodule

### hdl/text_terminal_escape_engine.sv
// top level: apb register, request front end and execution back end
// timing: a plain byte or cursor command is answered in the cycle after it leaves the queue,
//   a cell read passes the registered ram read and ST_READ; erase walks clear cells one by
//   one (up to 2000); scrolls copy cells via ST_COPY_RD and ST_COPY_WR, then clear; colour
//   changes walk all 16 slots; throughput: one plain byte request a cycle while results are
//   taken; reset: synchronous active low, then a clearing pass over all 2000 screen ram
//   cells during which no request is taken; configuration writes are taken throughout
`timescale 1ns / 1ps
module text_terminal_escape_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tte_in_if.sink                        i_item,
    tte_out_if.source                     o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tte_pkg::PADDR_W-1:0]   paddr,
    input  logic [tte_pkg::PDATA_W-1:0]   pwdata,
    output logic [tte_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import tte_pkg::*;

    // the only register sits at byte address zero
    localparam logic [PADDR_W-1:0] REG_DEFAULT_ATTR = '0;

    logic [ATTR_W-1:0] r_default_attr, n_default_attr;
    logic              w_cfg_write;
    logic              w_q_valid;
    t_item             w_q_item;
    logic              w_pop;
    t_back_status      w_status;

    // apb: no wait states, full byte address decoded
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        n_default_attr = r_default_attr;
        if (w_cfg_write && paddr == REG_DEFAULT_ATTR) begin
            n_default_attr = pwdata[ATTR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_attr <= ATTR_RESET;
        end else begin
            r_default_attr <= n_default_attr;
        end
    end

    assign prdata = {{(PDATA_W - ATTR_W){1'b0}}, r_default_attr};

    // front end: classifies bytes and buffers requests
    tte_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_status  (w_status),
        .i_pop     (w_pop),
        .o_q_valid (w_q_valid),
        .o_q_item  (w_q_item)
    );

    // back end: parser state, cursor, screen walks and the result register
    tte_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_default_attr (r_default_attr),
        .i_q_valid      (w_q_valid),
        .i_q_item       (w_q_item),
        .o_pop          (w_pop),
        .o_status       (w_status),
        .o_result       (o_result)
    );
endmodule

### tb/testbench.sv
// self-checking testbench for the text terminal escape engine
`timescale 1ns / 1ps
module testbench;
    import tte_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    localparam logic [PADDR_W-1:0] REG_DEFAULT_ATTR = '0;

    tte_in_if  req_ch ();
    tte_out_if res_ch ();

    text_terminal_escape_engine dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(req_ch.sink), .o_result(res_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    // expected terminal view after one request
    typedef struct packed {
        logic [CELL_W-1:0] cell_data;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [ATTR_W-1:0] attr;
        logic [1:0]        mode;
    } t_view;

    // terminal shadow state
    logic [CELL_W-1:0] sh_cells [CELLS];
    int unsigned sh_col, sh_row, sh_scol, sh_srow;
    logic [ATTR_W-1:0] sh_attr, sh_dflt;
    t_mode sh_mode;
    int unsigned sh_args [MAX_ARGS];
    bit sh_has [MAX_ARGS];
    int unsigned sh_slot;

    t_view expected_views [$];
    int mismatches;
    int stall_pat;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #300ms;
        $display("text_terminal_escape_engine regression: fail");
        $finish;
    end

    function automatic void wipe(int unsigned from, int unsigned to);
        if (to > CELLS) to = CELLS;
        for (int unsigned k = from; k < to; k++) sh_cells[k] = '0;
    endfunction

    function automatic void roll_up(int unsigned n);
        if (n > ROWS) n = ROWS;
        if (n == 0) return;
        for (int unsigned k = 0; k < (ROWS - n) * COLUMNS; k++)
            sh_cells[k] = sh_cells[k + n * COLUMNS];
        wipe((ROWS - n) * COLUMNS, CELLS);
    endfunction

    function automatic void roll_down(int unsigned n);
        if (n > ROWS) n = ROWS;
        if (n == 0) return;
        for (int k = (ROWS - n) * COLUMNS - 1; k >= 0; k--)
            sh_cells[k + n * COLUMNS] = sh_cells[k];
        wipe(0, n * COLUMNS);
    endfunction

    function automatic void sgr_code(int unsigned v);
        logic [2:0] fg [8];
        logic [ATTR_W-1:0] a;
        fg = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};
        a = sh_attr;
        if (v == 0) a = sh_dflt;
        else if (v == 1) a = a | 8'h08;
        else if (v == 22) a = a & 8'hF7;
        else if (v >= 30 && v <= 37) a = (a & 8'hF8) | {5'b0, fg[v - 30]};
        else if (v == 39) a = (a & 8'hF8) | 8'h07;
        else if (v >= 40 && v <= 47) a = (a & 8'h0F) | {1'b0, fg[v - 40], 4'b0};
        else if (v == 49) a = a & 8'h0F;
        sh_attr = a;
    endfunction

    function automatic void new_line();
        sh_col = 0;
        sh_row++;
        if (sh_row > ROWS - 1) begin
            roll_up(1);
            sh_row = ROWS - 1;
        end
    endfunction

    function automatic void run_final(logic [7:0] c);
        int unsigned p, here, x, s, base;
        bit any;
        p = sh_has[0] ? sh_args[0] : 1;
        here = sh_row * COLUMNS + sh_col;
        s = sh_has[0] ? sh_args[0] : 0;
        base = sh_row * COLUMNS;
        case (c)
            FIN_CUU: sh_row = (sh_row < p) ? 0 : sh_row - p;
            FIN_CUD: sh_row = (sh_row + p >= ROWS) ? ROWS - 1 : sh_row + p;
            FIN_CUF: sh_col = (sh_col + p >= COLUMNS) ? COLUMNS - 1 : sh_col + p;
            FIN_CUB: sh_col = (sh_col < p) ? 0 : sh_col - p;
            FIN_CNL: begin
                sh_row = (sh_row + p >= ROWS) ? ROWS - 1 : sh_row + p;
                sh_col = 0;
            end
            FIN_CPL: begin
                sh_row = (sh_row < p) ? 0 : sh_row - p;
                sh_col = 0;
            end
            FIN_CHA: if (p > 0 && p <= COLUMNS) sh_col = p - 1;
            FIN_CUP, FIN_HVP: begin
                x = sh_has[1] ? sh_args[1] : 1;
                if (x > 0 && x <= COLUMNS && p > 0 && p <= ROWS) begin
                    sh_col = x - 1;
                    sh_row = p - 1;
                end
            end
            FIN_ED: begin
                if (s == 0) wipe(here, CELLS);
                else if (s == 1) wipe(0, here);
                else if (s == 2) wipe(0, CELLS);
            end
            FIN_EL: begin
                if (s == 0) wipe(here, base + COLUMNS);
                else if (s == 1) wipe(base, here);
                else if (s == 2) wipe(base, base + COLUMNS);
            end
            FIN_SU:  roll_up(p);
            FIN_SD:  roll_down(p);
            FIN_VPA: if (p > 0 && p <= ROWS) sh_row = p - 1;
            FIN_SGR: begin
                any = 0;
                for (int k = 0; k < MAX_ARGS; k++)
                    if (sh_has[k]) begin
                        any = 1;
                        sgr_code(sh_args[k]);
                    end
                if (!any) sgr_code(0);
            end
            FIN_SCP: begin
                sh_scol = sh_col;
                sh_srow = sh_row;
            end
            FIN_RCP: begin
                sh_col = sh_scol;
                sh_row = sh_srow;
            end
            default: ;
        endcase
        sh_mode = MODE_NORMAL;
    endfunction

    function automatic void take_byte(logic [7:0] c);
        int unsigned v;
        case (sh_mode)
            MODE_NORMAL: begin
                if (c == CH_ESC) sh_mode = MODE_ESC;
                else if (c == CH_NUL) begin
                    sh_col = 0;
                    sh_row = 0;
                    wipe(0, CELLS);
                end else if (c == CH_LF) new_line();
                else begin
                    if (sh_col > COLUMNS - 1) new_line();
                    sh_cells[sh_row * COLUMNS + sh_col] = {sh_attr, c};
                    sh_col++;
                end
            end
            MODE_ESC: begin
                if (c == CH_LBR) begin
                    for (int k = 0; k < MAX_ARGS; k++) begin
                        sh_args[k] = 0;
                        sh_has[k] = 0;
                    end
                    sh_slot = 0;
                    sh_mode = MODE_CSI;
                end else if (c == CH_LC) begin
                    wipe(0, CELLS);
                    sh_col = 0; sh_row = 0; sh_scol = 0; sh_srow = 0;
                    sh_attr = sh_dflt;
                    sh_mode = MODE_NORMAL;
                end else sh_mode = MODE_NORMAL;
            end
            default: begin
                if (c >= CH_0 && c <= CH_9) begin
                    v = sh_args[sh_slot % MAX_ARGS] * 10 + (c - CH_0);
                    sh_args[sh_slot % MAX_ARGS] = (v > ARG_MAX) ? ARG_MAX : v;
                    sh_has[sh_slot % MAX_ARGS] = 1;
                end else if (c == CH_SEMI) begin
                    sh_slot++;
                    if (sh_slot >= MAX_ARGS) sh_mode = MODE_NORMAL;
                end else run_final(c);
            end
        endcase
    endfunction

    function automatic t_view predict_request(logic cmd, logic [7:0] c, logic [ADDR_W-1:0] a);
        t_view r;
        r.cell_data = '0;
        if (!cmd) take_byte(c);
        else if (a < CELLS) r.cell_data = sh_cells[a];
        r.col = COL_W'(sh_col);
        r.row = ROW_W'(sh_row);
        r.attr = sh_attr;
        r.mode = sh_mode;
        return r;
    endfunction

    // sender burst bookkeeping
    int burst_left;

    task automatic send_request(logic cmd, logic [7:0] c, logic [ADDR_W-1:0] a);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        req_ch.valid <= 1'b1;
        req_ch.cmd <= cmd;
        req_ch.char_byte <= c;
        req_ch.cell_address <= a;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        expected_views.push_back(predict_request(cmd, c, a));
    endtask

    task automatic send_text(string s);
        for (int k = 0; k < s.len(); k++) send_request(1'b0, s[k], '0);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_views.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_default_attr(logic [ATTR_W-1:0] v);
        drain();
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= REG_DEFAULT_ATTR; pwdata <= PDATA_W'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sh_dflt = v;
    endtask

    // result checker with stall pattern on ready
    always @(posedge i_clk) begin
        t_view want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_views.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
            end else begin
                want = expected_views.pop_front();
                if (res_ch.cell_data !== want.cell_data || res_ch.cursor_col !== want.col
                        || res_ch.cursor_row !== want.row
                        || res_ch.current_attribute !== want.attr
                        || res_ch.parse_mode !== want.mode) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: cell %h/%h col %0d/%0d row %0d/%0d attr %h/%h mode %0d/%0d",
                            want.cell_data, res_ch.cell_data, want.col, res_ch.cursor_col,
                            want.row, res_ch.cursor_row, want.attr, res_ch.current_attribute,
                            want.mode, res_ch.parse_mode);
                end
            end
        end
        stall_pat <= stall_pat + 1;
        // long free-running stretches, then a choppy phase
        res_ch.ready <= (stall_pat[8]) ? ($urandom_range(0, 2) != 0) : 1'b1;
    end

    task automatic test_printing();
        send_text("Hi");
        send_request(1'b0, 8'h01, '0);
        send_request(1'b0, 8'hFF, '0);
        send_request(1'b0, CH_LF, '0);
        send_request(1'b1, '0, 11'd0);
        send_request(1'b1, '0, 11'd1);
        send_request(1'b1, '0, 11'd1999);
        send_request(1'b1, '0, 11'd2000);
        send_request(1'b1, '0, 11'h7FF);
        send_text("\033[25;80H");
        send_text("XY");
        send_request(1'b1, '0, 11'd1999);
        send_request(1'b0, CH_NUL, '0);
    endtask

    task automatic test_escapes();
        send_text("\033c\033q\033[5Z\033[99999m\033[;H");
        send_text("\033[0;0;0;0;0;0;0;0;0;0;0;0;0;0;0;0;7m");
        send_text("\033[1;31;42m\033[m\033[3S\033[30T\033[0S\033[0A\033[0E\033[0F");
        send_text("\033[200C\033[81G\033[80G\033[26d\033[25d\033[7J\033[7K\033[s\033[H\033[u");
        send_text("\033[\033");
    endtask

    task automatic random_sequence();
        int sel;
        string fins;
        fins = "ABCDEFGHfJKSTdmsuZ";
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
            repeat ($urandom_range(1, 12)) send_request(1'b0, 8'($urandom_range(32, 126)), '0);
        end else if (sel < 60) begin
            send_request(1'b0, CH_ESC, '0);
            send_request(1'b0, CH_LBR, '0);
            repeat ($urandom_range(0, 3)) begin
                repeat ($urandom_range(0, 2))
                    send_request(1'b0, 8'(CH_0 + $urandom_range(0, 9)), '0);
                if ($urandom_range(0, 1)) send_request(1'b0, CH_SEMI, '0);
            end
            send_request(1'b0, fins[$urandom_range(0, fins.len() - 1)], '0);
        end else if (sel < 75) begin
            send_request(1'b1, '0, 11'($urandom_range(0, 2047)));
        end else if (sel < 82) begin
            send_request(1'b0, CH_LF, '0);
        end else if (sel < 84) begin
            send_text(($urandom_range(0, 1)) ? "\033c" : "\033[2J");
        end else if (sel < 86) begin
            send_request(1'b0, CH_NUL, '0);
        end else begin
            send_request(1'b0, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
        end
    endtask

    // each random sequence carries about four requests
    task automatic test_random();
        for (int n = 0; n < 360; n++) begin
            random_sequence();
            if (n == 120) write_default_attr(8'hFF);
            if (n == 240) write_default_attr(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        req_ch.valid = 1'b0; req_ch.cmd = 1'b0; req_ch.char_byte = '0;
        req_ch.cell_address = '0; res_ch.ready = 1'b1;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        stall_pat = 0; mismatches = 0; burst_left = 0;
        for (int k = 0; k < CELLS; k++) sh_cells[k] = '0;
        sh_col = 0; sh_row = 0; sh_scol = 0; sh_srow = 0;
        sh_attr = ATTR_RESET; sh_dflt = ATTR_RESET; sh_mode = MODE_NORMAL; sh_slot = 0;
        for (int k = 0; k < MAX_ARGS; k++) begin
            sh_args[k] = 0;
            sh_has[k] = 0;
        end
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_default_attr(8'h00);
        test_printing();
        write_default_attr(8'h5A);
        test_escapes();
        test_random();
        drain();
        repeat (4100) @(posedge i_clk);
        if (mismatches == 0 && expected_views.size() == 0)
            $display("text_terminal_escape_engine regression: pass");
        else
            $display("text_terminal_escape_engine regression: fail");
        $finish;
    end
endmodule

### text_terminal_escape_engine.f
hdl/tte_pkg.sv
hdl/tte_if.sv
hdl/tte_ram.sv
hdl/tte_front.sv
hdl/tte_back.sv
hdl/text_terminal_escape_engine.sv
tb/testbench.sv
